>>> rtl/core/bola_pkg.sv
// ----------------------------------------------------------------------------
// bola_pkg
// Shared types and constants for the bus owner lease arbiter.
// ----------------------------------------------------------------------------
package bola_pkg;

	localparam int ID_W       = 3;
	localparam int CMD_W      = 2;
	localparam int NOW_W      = 32;
	localparam int TIMEOUT_W  = 16;
	localparam int TIME_BITS  = 32;
	localparam int MAX_OWNERS = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(750);
	localparam logic [ID_W-1:0]      PRIO_RESET    = ID_W'(1);
	localparam logic [ID_W-1:0]      ID_NONE       = '0;

	localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TOUCH   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_OWNER = 2'd1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ID_W-1:0]  requester;
		logic [NOW_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic            granted;
		logic [ID_W-1:0] owner;
	} rsp_t;

endpackage

>>> rtl/core/bola_req_if.sv
// ----------------------------------------------------------------------------
// bola_req_if
// Request channel: command, requester id and current time.
// ----------------------------------------------------------------------------
interface bola_req_if;
	logic                          valid;
	logic                          ready;
	logic [bola_pkg::CMD_W-1:0]    command;
	logic [bola_pkg::ID_W-1:0]     requester;
	logic [bola_pkg::NOW_W-1:0]    now_ms;

	modport source (output valid, command, requester, now_ms, input ready);
	modport sink   (input valid, command, requester, now_ms, output ready);
endinterface

>>> rtl/core/bola_rsp_if.sv
// ----------------------------------------------------------------------------
// bola_rsp_if
// Response channel: grant flag and bus owner after the request.
// ----------------------------------------------------------------------------
interface bola_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      granted;
	logic [bola_pkg::ID_W-1:0] owner;

	modport source (output valid, granted, owner, input ready);
	modport sink   (input valid, granted, owner, output ready);
endinterface

>>> rtl/core/bola_cfg_if.sv
// ----------------------------------------------------------------------------
// bola_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bola_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bola_pkg::CFG_IDX_W-1:0]  index;
	logic [bola_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/bola_lease.sv
// ----------------------------------------------------------------------------
// bola_lease
// Lease state (holder and last touch time) and the per-request decision.
// ----------------------------------------------------------------------------
module bola_lease (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  bola_pkg::req_t                       req,
	input  logic [bola_pkg::TIMEOUT_W-1:0]       idle_timeout,
	input  logic [bola_pkg::ID_W-1:0]            prio_owner,
	output bola_pkg::rsp_t                       result
);
	import bola_pkg::*;

	logic [ID_W-1:0] holder_q;
	time_t           last_touch_q;

	time_t           now_t;
	time_t           idle;
	logic            id_ok;
	logic            is_prio;
	logic            is_holder;
	logic            claim_ok;
	logic            do_touch;
	logic            do_release;
	logic [ID_W-1:0] holder_d;

	assign now_t     = TIME_BITS'(req.now_ms);
	// wrapping difference, unsigned
	assign idle      = now_t - last_touch_q;
	assign id_ok     = int'(req.requester) <= MAX_OWNERS;
	assign is_prio   = req.requester == prio_owner;
	assign is_holder = req.requester == holder_q;

	always_comb begin
		claim_ok   = 1'b0;
		do_touch   = 1'b0;
		do_release = 1'b0;
		if (id_ok) begin
			case (req.command)
				CMD_CLAIM: begin
					claim_ok = is_prio || holder_q == ID_NONE || is_holder ||
						idle > TIME_BITS'(idle_timeout);
				end
				CMD_TOUCH:   do_touch   = is_holder || is_prio;
				CMD_RELEASE: do_release = is_holder;
				default: ;
			endcase
		end
	end

	always_comb begin
		holder_d = holder_q;
		if (claim_ok)
			holder_d = req.requester;
		else if (do_release)
			holder_d = ID_NONE;
	end

	assign result.granted = claim_ok;
	assign result.owner   = holder_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q     <= ID_NONE;
			last_touch_q <= '0;
		end else if (advance) begin
			holder_q <= holder_d;
			if (claim_ok || do_touch)
				last_touch_q <= now_t;
		end
	end

endmodule

>>> rtl/core/bus_owner_lease_arbiter_top.sv
// ----------------------------------------------------------------------------
// bus_owner_lease_arbiter_top
// Single-owner bus lease arbiter: claim, touch, release and query requests.
//
//   channel  role   transaction carries
//   req      sink   command, requester, now_ms
//   rsp      source granted, owner
//   cfg      sink   index, data (0 idle timeout, 1 priority owner)
//
// One request per cycle sustained while rsp is ready; req reaches rsp via two registers.
// The request register feeds the lease decision, whose result is captured
// in the response register at the same edge the holder state updates.
// A stalled rsp holds the result; req is still taken while the request
// register is empty. Reset frees the bus and loads the default registers.
// ----------------------------------------------------------------------------
module bus_owner_lease_arbiter_top (
	input  logic       clk,
	input  logic       arst_n,
	bola_req_if.sink   req,
	bola_rsp_if.source rsp,
	bola_cfg_if.sink   cfg
);
	import bola_pkg::*;

	logic [TIMEOUT_W-1:0] idle_timeout_q;
	logic [ID_W-1:0]      prio_owner_q;

	req_t  req_s1;
	logic  valid_s1;
	rsp_t  rsp_s2;
	logic  valid_s2;
	rsp_t  result;
	logic  advance;
	logic  take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= TIMEOUT_RESET;
			prio_owner_q   <= PRIO_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IDLE_TIMEOUT:   idle_timeout_q <= TIMEOUT_W'(cfg.data);
				REG_PRIORITY_OWNER: prio_owner_q   <= cfg.data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// advance when the response slot is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.command   <= req.command;
			req_s1.requester <= req.requester;
			req_s1.now_ms    <= req.now_ms;
		end
		if (advance)
			rsp_s2 <= result;
	end

	bola_lease u_lease (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.req          (req_s1),
		.idle_timeout (idle_timeout_q),
		.prio_owner   (prio_owner_q),
		.result       (result)
	);

	assign rsp.valid   = valid_s2;
	assign rsp.granted = rsp_s2.granted;
	assign rsp.owner   = rsp_s2.owner;

endmodule

>>> verif/bola_lease_checker.sv
// ----------------------------------------------------------------------------
// bola_lease_checker
// Watches the request, response and configuration channels of the lease
// arbiter. Tracks the timeout and priority registers from observed writes,
// predicts grant and owner for every accepted request, and compares each
// accepted response in order against the oldest prediction.
// ----------------------------------------------------------------------------
module bola_lease_checker (
	input  logic clk,
	input  logic arst_n,
	bola_req_if  req,
	bola_rsp_if  rsp,
	bola_cfg_if  cfg,
	output int   mismatches,
	output int   pending
);
	import bola_pkg::*;

	logic [TIMEOUT_W-1:0] idle_limit;
	logic [ID_W-1:0]      prio_id;
	logic [ID_W-1:0]      holder;
	time_t                lease_stamp;
	rsp_t                 owed_rsp_q[$];
	int                   fail_count;

	// Lease decision for one request; updates the holder and the lease stamp.
	function automatic rsp_t apply_lease_request(input logic [CMD_W-1:0] cmd,
			input logic [ID_W-1:0] who, input time_t now_ms);
		rsp_t  r;
		time_t idle;
		r.granted = 1'b0;
		// wrapping difference: a very old stamp can look fresh again
		idle = now_ms - lease_stamp;
		if (int'(who) <= MAX_OWNERS) begin
			case (cmd)
				CMD_CLAIM: begin
					if (who == prio_id || holder == ID_NONE || holder == who ||
							idle > time_t'(idle_limit)) begin
						holder      = who;
						lease_stamp = now_ms;
						r.granted   = 1'b1;
					end
				end
				CMD_TOUCH: begin
					if (who == holder || who == prio_id)
						lease_stamp = now_ms;
				end
				CMD_RELEASE: begin
					if (who == holder)
						holder = ID_NONE;
				end
				default: ;
			endcase
		end
		r.owner = holder;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			idle_limit  = TIMEOUT_RESET;
			prio_id     = PRIO_RESET;
			holder      = ID_NONE;
			lease_stamp = '0;
			fail_count  = 0;
			owed_rsp_q.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_IDLE_TIMEOUT:   idle_limit = cfg.data;
					REG_PRIORITY_OWNER: prio_id = cfg.data[ID_W-1:0];
					default: ;
				endcase
			end
			// compare before predicting: a response never belongs to this edge's request
			if (rsp.valid && rsp.ready) begin
				if (owed_rsp_q.size() == 0) begin
					$error("unexpected response: granted %0b, owner %0d", rsp.granted, rsp.owner);
					fail_count++;
				end else begin
					want = owed_rsp_q.pop_front();
					if (rsp.granted !== want.granted) begin
						$error("granted mismatch: expected %0b, actual %0b", want.granted,
							rsp.granted);
						fail_count++;
					end
					if (rsp.owner !== want.owner) begin
						$error("owner mismatch: expected %0d, actual %0d", want.owner, rsp.owner);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				owed_rsp_q.push_back(apply_lease_request(req.command, req.requester,
					req.now_ms));
			mismatches <= fail_count;
			pending    <= owed_rsp_q.size();
		end
	end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bus owner lease arbiter. A directed opening
// walks the lease rules (timeout edge, priority claims, releases, id zero,
// time wrap), then random claim/touch/release/query traffic runs under
// several register settings with random gaps on both sides. The checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
	import bola_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                 clk;
	logic                 arst_n;
	bit                   calm;
	time_t                wall_ms;
	logic [TIMEOUT_W-1:0] cur_timeout;
	int                   mismatches;
	int                   pending;
	int                   cycle_count = 0;

	bola_req_if req_ch ();
	bola_rsp_if rsp_ch ();
	bola_cfg_if cfg_ch ();

	bus_owner_lease_arbiter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	bola_lease_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Response side: ready in random stretches, short stalls until the calm tail.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
			if (!calm) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] who,
			input time_t now_ms, input int gap_pct);
		req_ch.valid     <= 1'b1;
		req_ch.command   <= cmd;
		req_ch.requester <= who;
		req_ch.now_ms    <= now_ms;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (!calm && $urandom_range(1, 100) <= gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Registers change only with nothing in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_responses();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_IDLE_TIMEOUT)
			cur_timeout = data;
		@(posedge clk);
	endtask

	// Mostly advancing time with steps around the timeout, plus jumps.
	task automatic lease_traffic(input int n_items, input int gap_pct);
		int               pick;
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  who;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				cmd = CMD_CLAIM;
			else if (pick < 65)
				cmd = CMD_TOUCH;
			else if (pick < 85)
				cmd = CMD_RELEASE;
			else
				cmd = CMD_QUERY;
			who = ID_W'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: wall_ms += $urandom_range(0, int'(cur_timeout));
				4, 5:       wall_ms += time_t'(cur_timeout) - 1 + $urandom_range(0, 2);
				6, 7:       wall_ms += $urandom_range(int'(cur_timeout) + 1,
						int'(cur_timeout) + 5000);
				8:          ;
				default:    wall_ms = $urandom();
			endcase
			send_request(cmd, who, wall_ms, gap_pct);
		end
	endtask

	initial begin
		req_ch.valid     <= 1'b0;
		req_ch.command   <= CMD_QUERY;
		req_ch.requester <= ID_NONE;
		req_ch.now_ms    <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= REG_IDLE_TIMEOUT;
		cfg_ch.data      <= '0;
		calm        = 1'b0;
		wall_ms     = '0;
		cur_timeout = TIMEOUT_RESET;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: timeout 750, priority owner 1
		send_request(CMD_QUERY,   3'd0, 32'd0,    20);
		send_request(CMD_CLAIM,   3'd3, 32'd100,  20);
		send_request(CMD_CLAIM,   3'd4, 32'd850,  20); // idle equals timeout: denied
		send_request(CMD_CLAIM,   3'd4, 32'd851,  20); // one past: taken over
		send_request(CMD_TOUCH,   3'd2, 32'd900,  20);
		send_request(CMD_TOUCH,   3'd1, 32'd900,  20); // priority owner refreshes
		send_request(CMD_CLAIM,   3'd5, 32'd1650, 20);
		send_request(CMD_CLAIM,   3'd1, 32'd1650, 20);
		send_request(CMD_RELEASE, 3'd3, 32'd1700, 20);
		send_request(CMD_RELEASE, 3'd1, 32'd1700, 20);
		send_request(CMD_RELEASE, 3'd0, 32'd1700, 20);
		send_request(CMD_CLAIM,   3'd0, 32'd1800, 20); // granted, bus stays free
		send_request(CMD_TOUCH,   3'd0, 32'd1900, 20);
		send_request(CMD_CLAIM,   3'd7, 32'hFFFF_FFFF, 20);
		send_request(CMD_CLAIM,   3'd6, 32'h0000_0000, 20); // wrapped idle of one
		send_request(CMD_CLAIM,   3'd6, 32'h8000_0000, 20);
		send_request(CMD_CLAIM,   3'd6, 32'h8000_0001, 20);
		send_request(CMD_TOUCH,   3'd5, 32'hC000_0000, 20);
		send_request(CMD_QUERY,   3'd7, 32'hFFFF_FFFF, 20);
		send_request(CMD_RELEASE, 3'd6, 32'hFFFF_FFFF, 20);
		wall_ms = 32'hFFFF_FFFF;
		lease_traffic(150, 25);

		write_reg(REG_IDLE_TIMEOUT, 16'd0);
		write_reg(REG_PRIORITY_OWNER, 16'd0);
		lease_traffic(200, 40);

		write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
		write_reg(REG_PRIORITY_OWNER, 16'hFFFF);
		write_reg(REG_SPARE_2, 16'hFFFF);
		write_reg(REG_SPARE_3, 16'h0000);
		lease_traffic(200, 10);

		write_reg(REG_IDLE_TIMEOUT, 16'd1);
		write_reg(REG_PRIORITY_OWNER, 16'd3);
		lease_traffic(200, 60);

		write_reg(REG_IDLE_TIMEOUT, CFG_DATA_W'($urandom_range(0, 3000)));
		write_reg(REG_PRIORITY_OWNER, CFG_DATA_W'($urandom()));
		lease_traffic(200, 0);

		write_reg(REG_IDLE_TIMEOUT, 16'd50);
		write_reg(REG_PRIORITY_OWNER, 16'd5);
		lease_traffic(200, 30);

		write_reg(REG_IDLE_TIMEOUT, 16'd750);
		write_reg(REG_PRIORITY_OWNER, 16'd2);
		calm = 1'b1;
		lease_traffic(250, 0);

		drain_responses();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
